FILE: design/swept_point_circle_hit_time_assert.svh
// Assertion macros for the hit time block.
`ifndef SWEPT_POINT_CIRCLE_HIT_TIME_ASSERT_SVH
`define SWEPT_POINT_CIRCLE_HIT_TIME_ASSERT_SVH

// Antecedent implies consequent on the same edge.
`define SPC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Antecedent implies consequent on the next edge.
`define SPC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: design/spc_pkg.sv
package spc_pkg;
    typedef enum logic [2:0] {
        OC_HIT     = 3'd0,
        OC_INSIDE  = 3'd1,
        OC_OWN     = 3'd2,
        OC_BOX     = 3'd3,
        OC_RECEDE  = 3'd4,
        OC_NO_ROOT = 3'd5
    } outcome_t;

    localparam int VEL_W    = 16;
    localparam int ID_W     = 16;
    localparam int RAD_W    = 16;
    localparam int OUT_T_W  = 18;
    localparam int REL_W    = 18;  // |rx|,|ry| < 2^17 past the box test
    localparam int RV_W     = 37;  // signed r.v
    localparam int C_W      = 37;  // signed c
    localparam int V2_W     = 35;  // unsigned |v|^2
    localparam int DISC_W   = 74;  // rv^2, v2*c
    localparam int SQRT_W   = 37;

    // Control fields that ride the pipeline next to the numbers.
    typedef struct packed {
        logic     valid;
        logic     done;     // outcome already decided
        outcome_t code;
    } ctl_t;
endpackage

FILE: design/swept_point_circle_hit_time.sv
// Swept point versus circle hit time. A fully pipelined unit: one item may be
// started every cycle (busy is tied low) and its result appears on done with
// hit_time, hit and outcome after the front stages, the discriminant stages,
// the 37-stage square root, the range check, the TIME_FRAC_BITS+1 stage divider
// and the output register. The result is held for exactly one cycle; there is no backpressure,
// so the receiver must take every transfer when done is high. Early rejects
// (own shot, box, inside, receding, no root) ride the same pipeline so order
// is preserved. max_speed resets to 60.0 (Q8.8) and is written through
// cfg_we/cfg_data.
module swept_point_circle_hit_time
    import spc_pkg::*;
#(
    parameter int COORD_WIDTH    = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] shot_x,
    input  logic signed [COORD_WIDTH-1:0] shot_y,
    input  logic signed [VEL_W-1:0]       shot_vx,
    input  logic signed [VEL_W-1:0]       shot_vy,
    input  logic [ID_W-1:0]               shot_owner,
    input  logic [ID_W-1:0]               target_id,
    input  logic signed [COORD_WIDTH-1:0] target_x,
    input  logic signed [COORD_WIDTH-1:0] target_y,
    input  logic signed [VEL_W-1:0]       target_vx,
    input  logic signed [VEL_W-1:0]       target_vy,
    input  logic [RAD_W-1:0]              target_radius,
    output logic                          done,
    output logic [OUT_T_W-1:0]            hit_time,
    output logic                          hit,
    output logic [2:0]                    outcome
);
    logic [15:0]          max_speed_reg;
    ctl_t                 f_ctl, d_ctl, s_ctl;
    logic signed [C_W-1:0]  c_val;
    logic signed [RV_W-1:0] rv_val;
    logic [V2_W-1:0]      v2_f, v2_d, v2_s;
    logic [DISC_W-1:0]    disc;
    logic [SQRT_W-1:0]    nrv_d, nrv_s, root;
    logic                 r_valid;
    logic [OUT_T_W-1:0]   r_time;
    outcome_t             r_code;
    logic                 done_reg;
    logic [OUT_T_W-1:0]   time_reg;
    outcome_t             code_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_speed_reg <= 16'd15360;
        else if (cfg_we)
            max_speed_reg <= cfg_data;
    end

    spc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk, .rst_n, .in_valid(start), .max_speed(max_speed_reg),
        .shot_x, .shot_y, .shot_vx, .shot_vy, .shot_owner, .target_id,
        .target_x, .target_y, .target_vx, .target_vy, .target_radius,
        .ctl(f_ctl), .c_val, .rv_val, .v2_val(v2_f)
    );

    spc_disc u_disc (
        .clk, .rst_n, .ctl_in(f_ctl), .c_in(c_val), .rv_in(rv_val),
        .v2_in(v2_f), .ctl_out(d_ctl), .disc, .nrv(nrv_d), .v2(v2_d)
    );

    spc_sqrt u_sqrt (
        .clk, .rst_n, .ctl_in(d_ctl), .disc, .nrv_in(nrv_d), .v2_in(v2_d),
        .ctl_out(s_ctl), .root, .nrv_out(nrv_s), .v2_out(v2_s)
    );

    spc_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div (
        .clk, .rst_n, .ctl_in(s_ctl), .root, .nrv(nrv_s), .v2_in(v2_s),
        .out_valid(r_valid), .out_time(r_time), .out_code(r_code)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= r_valid;
    end

    always_ff @(posedge clk)
    begin
        time_reg <= r_time;
        code_reg <= r_code;
    end

    assign done     = done_reg;
    assign hit_time = time_reg;
    assign outcome  = code_reg;
    assign hit      = (code_reg == OC_HIT) || (code_reg == OC_INSIDE);
endmodule

FILE: design/spc_front.sv
// Front stages: relative vectors, early rejects, products for c, r.v, |v|^2.
module spc_front
    import spc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [15:0]                   max_speed,
    input  logic signed [COORD_WIDTH-1:0] shot_x,
    input  logic signed [COORD_WIDTH-1:0] shot_y,
    input  logic signed [VEL_W-1:0]       shot_vx,
    input  logic signed [VEL_W-1:0]       shot_vy,
    input  logic [ID_W-1:0]               shot_owner,
    input  logic [ID_W-1:0]               target_id,
    input  logic signed [COORD_WIDTH-1:0] target_x,
    input  logic signed [COORD_WIDTH-1:0] target_y,
    input  logic signed [VEL_W-1:0]       target_vx,
    input  logic signed [VEL_W-1:0]       target_vy,
    input  logic [RAD_W-1:0]              target_radius,
    output ctl_t                          ctl,
    output logic signed [C_W-1:0]         c_val,
    output logic signed [RV_W-1:0]        rv_val,
    output logic [V2_W-1:0]               v2_val
);
    localparam int RW = COORD_WIDTH + 1;

    // stage 1: differences
    ctl_t                  s1_ctl_reg, s1_ctl_next;
    logic signed [RW-1:0]  rx_reg, ry_reg;
    logic signed [VEL_W:0] vx_reg, vy_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [RAD_W:0]        dmax_reg;
    // stage 2: magnitudes and box test
    ctl_t                  s2_ctl_reg, s2_ctl_next;
    logic signed [REL_W-1:0] rx2_reg, ry2_reg;
    logic signed [VEL_W:0] vx2_reg, vy2_reg;
    logic [RAD_W-1:0]      rad2_reg;
    // stage 3: products
    ctl_t                  s3_ctl_reg;
    logic [35:0]           pxx_reg, pyy_reg, pvv_x_reg, pvv_y_reg;
    logic [31:0]           prr_reg;
    logic signed [35:0]    prv_x_reg, prv_y_reg;
    // stage 4: sums
    ctl_t                  s4_ctl_reg, s4_ctl_next;
    logic signed [C_W-1:0] c_reg, c_next;
    logic signed [RV_W-1:0] rv_reg, rv_next;
    logic [V2_W-1:0]       v2_reg;

    logic [RW-1:0]         arx, ary;

    always_comb
    begin
        s1_ctl_next.valid = in_valid;
        s1_ctl_next.done  = (shot_owner == target_id);
        s1_ctl_next.code  = OC_OWN;
    end

    assign arx = rx_reg[RW-1] ? RW'(-rx_reg) : RW'(rx_reg);
    assign ary = ry_reg[RW-1] ? RW'(-ry_reg) : RW'(ry_reg);

    always_comb
    begin
        s2_ctl_next = s1_ctl_reg;
        if (!s1_ctl_reg.done && (arx >= RW'(dmax_reg) || ary >= RW'(dmax_reg)))
        begin
            s2_ctl_next.done = 1'b1;
            s2_ctl_next.code = OC_BOX;
        end
    end

    always_comb
    begin
        s4_ctl_next = s3_ctl_reg;
        c_next  = C_W'(pxx_reg) + C_W'(pyy_reg) - C_W'(prr_reg);
        rv_next = RV_W'(prv_x_reg) + RV_W'(prv_y_reg);
        if (!s3_ctl_reg.done && c_next <= 0)
        begin
            s4_ctl_next.done = 1'b1;
            s4_ctl_next.code = OC_INSIDE;
        end
        else if (!s3_ctl_reg.done && rv_next >= 0)
        begin
            s4_ctl_next.done = 1'b1;
            s4_ctl_next.code = OC_RECEDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s2_ctl_next;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s4_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg   <= RW'(shot_x) - RW'(target_x);
        ry_reg   <= RW'(shot_y) - RW'(target_y);
        vx_reg   <= (VEL_W+1)'(shot_vx) - (VEL_W+1)'(target_vx);
        vy_reg   <= (VEL_W+1)'(shot_vy) - (VEL_W+1)'(target_vy);
        rad_reg  <= target_radius;
        dmax_reg <= (RAD_W+1)'(target_radius) + (RAD_W+1)'(max_speed);

        rx2_reg  <= REL_W'(rx_reg);
        ry2_reg  <= REL_W'(ry_reg);
        vx2_reg  <= vx_reg;
        vy2_reg  <= vy_reg;
        rad2_reg <= rad_reg;

        pxx_reg   <= 36'(rx2_reg * rx2_reg);
        pyy_reg   <= 36'(ry2_reg * ry2_reg);
        prr_reg   <= rad2_reg * rad2_reg;
        pvv_x_reg <= 36'(vx2_reg * vx2_reg);
        pvv_y_reg <= 36'(vy2_reg * vy2_reg);
        prv_x_reg <= 36'(rx2_reg * vx2_reg);
        prv_y_reg <= 36'(ry2_reg * vy2_reg);

        c_reg  <= c_next;
        rv_reg <= rv_next;
        v2_reg <= V2_W'(pvv_x_reg) + V2_W'(pvv_y_reg);
    end

    assign ctl    = s4_ctl_reg;
    assign c_val  = c_reg;
    assign rv_val = rv_reg;
    assign v2_val = v2_reg;
endmodule

FILE: design/spc_disc.sv
// Discriminant: rv^2 and v2*c from 37x37 products cut into 19-bit halves.
module spc_disc
    import spc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_t                   ctl_in,
    input  logic signed [C_W-1:0]  c_in,
    input  logic signed [RV_W-1:0] rv_in,
    input  logic [V2_W-1:0]        v2_in,
    output ctl_t                   ctl_out,
    output logic [DISC_W-1:0]      disc,
    output logic [SQRT_W-1:0]      nrv,
    output logic [V2_W-1:0]        v2
);
    localparam int H = 19;

    ctl_t              a_ctl_reg, b_ctl_reg, b_ctl_next;
    logic [V2_W-1:0]   v2_a_reg, v2_b_reg;
    logic [SQRT_W-1:0] nrv_a_reg, nrv_b_reg;
    logic [2*H-1:0]    aa_ll_reg, aa_lh_reg, aa_hh_reg;
    logic [2*H-1:0]    bb_ll_reg, bb_lh_reg, bb_hl_reg, bb_hh_reg;
    logic [DISC_W-1:0] disc_reg;
    logic [DISC_W-1:0] asq, bprod;
    logic [2*H-1:0]    nrv_w, c_w, v2_w;

    assign nrv_w = (2*H)'(-rv_in);
    assign c_w   = (2*H)'(c_in);
    assign v2_w  = (2*H)'(v2_in);

    always_ff @(posedge clk)
    begin
        nrv_a_reg <= SQRT_W'(nrv_w);
        v2_a_reg  <= v2_in;
        aa_ll_reg <= nrv_w[H-1:0] * nrv_w[H-1:0];
        aa_lh_reg <= nrv_w[H-1:0] * nrv_w[2*H-1:H];
        aa_hh_reg <= nrv_w[2*H-1:H] * nrv_w[2*H-1:H];
        bb_ll_reg <= v2_w[H-1:0] * c_w[H-1:0];
        bb_lh_reg <= v2_w[H-1:0] * c_w[2*H-1:H];
        bb_hl_reg <= v2_w[2*H-1:H] * c_w[H-1:0];
        bb_hh_reg <= v2_w[2*H-1:H] * c_w[2*H-1:H];
    end

    always_comb
    begin
        asq   = DISC_W'(aa_ll_reg) + (DISC_W'(aa_lh_reg) << (H+1))
              + (DISC_W'(aa_hh_reg) << (2*H));
        bprod = DISC_W'(bb_ll_reg) + (DISC_W'(bb_lh_reg) << H)
              + (DISC_W'(bb_hl_reg) << H) + (DISC_W'(bb_hh_reg) << (2*H));
        b_ctl_next = a_ctl_reg;
        if (!a_ctl_reg.done && (asq <= bprod || v2_a_reg == '0))
        begin
            b_ctl_next.done = 1'b1;
            b_ctl_next.code = OC_NO_ROOT;
        end
    end

    always_ff @(posedge clk)
    begin
        disc_reg  <= asq - bprod;
        nrv_b_reg <= nrv_a_reg;
        v2_b_reg  <= v2_a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg <= ctl_in;
            b_ctl_reg <= b_ctl_next;
        end
    end

    assign ctl_out = b_ctl_reg;
    assign disc    = disc_reg;
    assign nrv     = nrv_b_reg;
    assign v2      = v2_b_reg;
endmodule

FILE: design/spc_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
module spc_sqrt
    import spc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl_in,
    input  logic [DISC_W-1:0] disc,
    input  logic [SQRT_W-1:0] nrv_in,
    input  logic [V2_W-1:0]   v2_in,
    output ctl_t              ctl_out,
    output logic [SQRT_W-1:0] root,
    output logic [SQRT_W-1:0] nrv_out,
    output logic [V2_W-1:0]   v2_out
);
    localparam int N  = SQRT_W;
    localparam int RW = N + 2;

    ctl_t              ctl_reg [N+1];
    logic [DISC_W-1:0] d_reg   [N+1];
    logic [RW-1:0]     rem_reg [N+1];
    logic [N-1:0]      q_reg   [N+1];
    logic [SQRT_W-1:0] nrv_reg [N+1];
    logic [V2_W-1:0]   v2_reg  [N+1];

    always_comb
    begin
        ctl_reg[0] = ctl_in;
        d_reg[0]   = disc;
        rem_reg[0] = '0;
        q_reg[0]   = '0;
        nrv_reg[0] = nrv_in;
        v2_reg[0]  = v2_in;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [RW-1:0] trial, rem_sh;
        always_comb
        begin
            rem_sh = {rem_reg[i][RW-3:0], d_reg[i][DISC_W-1 -: 2]};
            trial  = rem_sh - {q_reg[i], 2'b01};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i+1] <= '0;
            else
                ctl_reg[i+1] <= ctl_reg[i];
        end
        always_ff @(posedge clk)
        begin
            d_reg[i+1]   <= d_reg[i] << 2;
            nrv_reg[i+1] <= nrv_reg[i];
            v2_reg[i+1]  <= v2_reg[i];
            if (!trial[RW-1])
            begin
                rem_reg[i+1] <= trial;
                q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i+1] <= rem_sh;
                q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b0};
            end
        end
    end

    assign ctl_out = ctl_reg[N];
    assign root    = q_reg[N];
    assign nrv_out = nrv_reg[N];
    assign v2_out  = v2_reg[N];
endmodule

FILE: design/spc_div.sv
// Range check and pipelined restoring divide, one quotient bit per stage.
module spc_div
    import spc_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl_in,
    input  logic [SQRT_W-1:0] root,
    input  logic [SQRT_W-1:0] nrv,
    input  logic [V2_W-1:0]   v2_in,
    output logic              out_valid,
    output logic [OUT_T_W-1:0] out_time,
    output outcome_t          out_code
);
    localparam int NB = TIME_FRAC_BITS + 1;  // quotient bits, q <= v2
    localparam int RW = V2_W + 1;

    ctl_t            c0_ctl_reg, c0_ctl_next;
    logic [V2_W-1:0] q0_reg, v20_reg;
    ctl_t            ctl_reg [NB+1];
    logic [RW-1:0]   rem_reg [NB+1];
    logic [NB-1:0]   quo_reg [NB+1];
    logic [V2_W-1:0] dv_reg  [NB+1];
    logic [SQRT_W-1:0] qv;

    assign qv = nrv - root;

    always_comb
    begin
        c0_ctl_next = ctl_in;
        if (!ctl_in.done && V2_W'(qv) > v2_in)
        begin
            c0_ctl_next.done = 1'b1;
            c0_ctl_next.code = OC_NO_ROOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c0_ctl_reg <= '0;
        else
            c0_ctl_reg <= c0_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        q0_reg  <= V2_W'(qv);
        v20_reg <= v2_in;
    end

    // q <= v2, so q*2^F / v2 fits NB bits; first remainder is q itself
    always_comb
    begin
        ctl_reg[0] = c0_ctl_reg;
        rem_reg[0] = RW'(q0_reg);
        quo_reg[0] = '0;
        dv_reg[0]  = v20_reg;
    end

    for (genvar i = 0; i < NB; i++)
    begin : g_step
        logic [RW-1:0] trial;
        assign trial = rem_reg[i] - RW'(dv_reg[i]);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i+1] <= '0;
            else
                ctl_reg[i+1] <= ctl_reg[i];
        end
        always_ff @(posedge clk)
        begin
            dv_reg[i+1] <= dv_reg[i];
            if (!trial[RW-1])
            begin
                rem_reg[i+1] <= RW'(trial << 1);
                quo_reg[i+1] <= {quo_reg[i][NB-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i+1] <= RW'(rem_reg[i] << 1);
                quo_reg[i+1] <= {quo_reg[i][NB-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        out_valid = ctl_reg[NB].valid;
        if (!ctl_reg[NB].done)
        begin
            out_code = OC_HIT;
            out_time = OUT_T_W'(quo_reg[NB]);
        end
        else
        begin
            out_code = ctl_reg[NB].code;
            if (ctl_reg[NB].code == OC_INSIDE)
                out_time = '0;
            else
                out_time = OUT_T_W'(2) << TIME_FRAC_BITS;
        end
    end
endmodule

FILE: design/spc_checker.sv
module spc_checker
    import spc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic [17:0] hit_time,
    input logic        hit,
    input logic [2:0]  outcome
);
`include "swept_point_circle_hit_time_assert.svh"

    `SPC_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)
    `SPC_ASSERT_IMP(a_hit_code, clk, rst_n, done, hit == (outcome <= 3'd1))
    `SPC_ASSERT_IMP(a_inside_zero, clk, rst_n, done && outcome == OC_INSIDE, hit_time == '0)
    `SPC_ASSERT_IMP(a_miss_time, clk, rst_n, done && !hit, hit_time == 18'h20000)
endmodule

bind swept_point_circle_hit_time spc_checker u_chk (
    .clk, .rst_n, .busy, .done, .hit_time, .hit, .outcome
);
